@@ src/bpa_pkg.sv @@
`default_nettype none
package bpa_pkg;

   localparam int NUM_PAGES    = 1024;
   localparam int ORDER_LEVELS = 10;
   localparam int IDX_W        = $clog2(NUM_PAGES);
   localparam int PTR_W        = IDX_W + 1;
   localparam int ORD_W        = 4;
   localparam int REQ_W        = 10;
   localparam int FREE_W       = 11;
   localparam int CFG_W        = 11;
   localparam int CSR_IDX_W    = 2;

   localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_PAGES);

   localparam logic [2:0] MK_NONE  = 3'h0;
   localparam logic [2:0] MK_ALLOC = 3'h1;
   localparam logic [2:0] MK_RSVD  = 3'h2;
   localparam logic [2:0] MK_FREE  = 3'h4;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_FREE    = 2'd1;
   localparam logic [1:0] OP_REBUILD = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOBLOCK = 2'd1;
   localparam logic [1:0] ST_BADREQ  = 2'd2;
   localparam logic [1:0] ST_BADFREE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END   = 2'd2;

   typedef struct packed {
      logic [ORD_W-1:0] order;
      logic [2:0]       marks;
   } meta_type;

endpackage
`default_nettype wire

@@ src/bpa_if.sv @@
`default_nettype none
interface bpa_req_if import bpa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       op;
   logic [REQ_W-1:0] request_pages;
   logic [IDX_W-1:0] free_index;
   modport source (output valid, op, request_pages, free_index, input ready);
   modport sink   (input valid, op, request_pages, free_index, output ready);
   modport mon    (input valid, ready, op, request_pages, free_index);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [IDX_W-1:0]  page_index;
   logic [ORD_W-1:0]  block_order;
   logic [FREE_W-1:0] free_pages;
   modport source (output valid, status, page_index, block_order, free_pages, input ready);
   modport sink   (input valid, status, page_index, block_order, free_pages, output ready);
   modport mon    (input valid, ready, status, page_index, block_order, free_pages);
endinterface

interface bpa_csr_if import bpa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
   modport mon    (input valid, ready, index, data);
endinterface
`default_nettype wire

@@ src/buddy_page_allocator.sv @@
// Allocate splits the block down; free merges with buddies, reading each buddy's page entry
// while one is in range; rebuild sweeps the page table, then queues each block. One request
// at a time; the page table and link memories, each with one write and one read port, set
// the pace. Reset (synchronous, active high) starts a clearing pass that marks every page
// reserved; no request is taken until it ends. Register writes are taken at any time.
`default_nettype none
module buddy_page_allocator import bpa_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   bpa_req_if.sink   req_ch,
   bpa_rsp_if.source rsp_ch,
   bpa_csr_if.sink   csr_ch
);

   typedef enum logic [15:0] {
      S_SWEEP     = 16'h0001,
      S_IDLE      = 16'h0002,
      S_BUILD     = 16'h0004,
      S_PUSH_B    = 16'h0008,
      S_PULL_A    = 16'h0010,
      S_PULL_B    = 16'h0020,
      S_FREE_W    = 16'h0040,
      S_FREE_RD   = 16'h0080,
      S_MERGE_CHK = 16'h0100,
      S_MERGE_W   = 16'h0200,
      S_MERGE_RD  = 16'h0400,
      S_MERGE_P2  = 16'h0800,
      S_HI        = 16'h1000,
      S_LO        = 16'h2000,
      S_SPLIT     = 16'h4000,
      S_DONE      = 16'h8000
   } state_type;

   // configuration
   logic [CFG_W-1:0] total_pages_ff, region_first_ff, region_end_ff;

   // sequencer
   state_type        state_ff, state_in, ret_ff, ret_in;
   logic [IDX_W-1:0] idx_ff, idx_in, bud_ff, bud_in, sweep_ff, sweep_in;
   logic [ORD_W-1:0] ord_ff, ord_in, ro_ff, ro_in;
   logic [ORD_W-1:0] lop_ord_ff, lop_ord_in;
   logic [IDX_W-1:0] lop_idx_ff, lop_idx_in;
   logic [PTR_W-1:0] i_ff, i_in, bend_ff, bend_in;
   logic             build_ff, build_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [IDX_W-1:0] res_idx_ff, res_idx_in;
   logic [ORD_W-1:0] res_ord_ff, res_ord_in;

   // per-order list heads, tails and counts
   logic [PTR_W-1:0]  first_ff [ORDER_LEVELS];
   logic [PTR_W-1:0]  first_in [ORDER_LEVELS];
   logic [PTR_W-1:0]  last_ff  [ORDER_LEVELS];
   logic [PTR_W-1:0]  last_in  [ORDER_LEVELS];
   logic [PTR_W-1:0]  cnt_ff   [ORDER_LEVELS];
   logic [PTR_W-1:0]  cnt_in   [ORDER_LEVELS];
   logic [FREE_W-1:0] free_ff, free_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [ORD_W-1:0]  rsp_ord_ff, rsp_ord_in;
   logic [FREE_W-1:0] rsp_free_ff, rsp_free_in;

   // memories
   meta_type         meta_mem [NUM_PAGES];
   logic [PTR_W-1:0] next_mem [NUM_PAGES];
   logic [PTR_W-1:0] prev_mem [NUM_PAGES];

   meta_type         meta_rd_ff, meta_wd;
   logic             meta_we;
   logic [IDX_W-1:0] meta_wa, meta_ra;
   logic [PTR_W-1:0] next_rd_ff, prev_rd_ff, next_wd, prev_wd;
   logic             next_we, prev_we;
   logic [IDX_W-1:0] next_wa, prev_wa;

   // push first half, requested by the states
   logic             push_go;
   logic [ORD_W-1:0] push_ord;
   logic [IDX_W-1:0] push_idx;

   // decode helpers
   logic [PTR_W-1:0] limit;
   logic [ORD_W-1:0] req_ro, fit_ord, build_ord;
   logic             fit_found, req_bad, build_run;
   logic [PTR_W:0]   build_sum;
   logic [IDX_W-1:0] bud_cand, lo_page, hi_page;
   logic [ORD_W-1:0] ord_up;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.page_index  = rsp_idx_ff;
   assign rsp_ch.block_order = rsp_ord_ff;
   assign rsp_ch.free_pages  = rsp_free_ff;

   assign limit = (total_pages_ff < PTR_W'(NUM_PAGES)) ? total_pages_ff : PTR_W'(NUM_PAGES);

   // round the request up to a power of two, then find the smallest non-empty order
   always_comb begin
      req_bad = (req_ch.request_pages == '0) ||
                (PTR_W'(req_ch.request_pages) > (PTR_W'(1) << (ORDER_LEVELS - 1)));
      req_ro = '0;
      for (int k = ORDER_LEVELS - 1; k >= 0; k--) begin
         if ((PTR_W'(1) << k) >= PTR_W'(req_ch.request_pages)) req_ro = ORD_W'(k);
      end
      fit_found = 1'b0;
      fit_ord   = '0;
      for (int k = ORDER_LEVELS - 1; k >= 0; k--) begin
         if ((ORD_W'(k) >= req_ro) && (cnt_ff[k] != '0)) begin
            fit_found = 1'b1;
            fit_ord   = ORD_W'(k);
         end
      end
   end

   // largest aligned block that starts at i_ff and stays below the region end
   always_comb begin
      build_run = 1'b1;
      build_ord = '0;
      build_sum = '0;
      for (int k = 1; k < ORDER_LEVELS; k++) begin
         build_sum = {1'b0, i_ff} + ((PTR_W + 1)'(1) << k);
         if (build_run && ((i_ff & ((PTR_W'(1) << k) - PTR_W'(1))) == '0) &&
             (build_sum <= {1'b0, bend_ff})) begin
            build_ord = ORD_W'(k);
         end else begin
            build_run = 1'b0;
         end
      end
   end

   assign bud_cand = idx_ff ^ (IDX_W'(1) << ord_ff);
   assign lo_page  = (idx_ff < bud_ff) ? idx_ff : bud_ff;
   assign hi_page  = (idx_ff < bud_ff) ? bud_ff : idx_ff;
   assign ord_up   = ord_ff + ORD_W'(1);
   assign meta_ra  = (state_ff == S_MERGE_W) ? bud_ff : idx_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      idx_in        = idx_ff;
      bud_in        = bud_ff;
      sweep_in      = sweep_ff;
      ord_in        = ord_ff;
      ro_in         = ro_ff;
      lop_ord_in    = lop_ord_ff;
      lop_idx_in    = lop_idx_ff;
      i_in          = i_ff;
      bend_in       = bend_ff;
      build_in      = build_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_ord_in    = res_ord_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      cnt_in        = cnt_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_ord_in    = rsp_ord_ff;
      rsp_free_in   = rsp_free_ff;
      meta_we       = 1'b0;
      meta_wa       = idx_ff;
      meta_wd       = '{order: '0, marks: MK_NONE};
      next_we       = 1'b0;
      next_wa       = lop_idx_ff;
      next_wd       = NIL;
      prev_we       = 1'b0;
      prev_wa       = lop_idx_ff;
      prev_wd       = NIL;
      push_go       = 1'b0;
      push_ord      = '0;
      push_idx      = '0;

      // drop the result once taken
      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_SWEEP: begin
            // mark pages of the rebuild region clear, all others reserved
            meta_we  = 1'b1;
            meta_wa  = sweep_ff;
            meta_wd  = '{order: '0,
                         marks: (({1'b0, sweep_ff} >= i_ff) && ({1'b0, sweep_ff} < bend_ff)) ?
                                MK_NONE : MK_RSVD};
            sweep_in = sweep_ff + IDX_W'(1);
            if (sweep_ff == IDX_W'(NUM_PAGES - 1)) state_in = build_ff ? S_BUILD : S_IDLE;
         end

         S_IDLE: begin
            if (req_ch.valid) begin
               res_idx_in = '0;
               res_ord_in = '0;
               case (req_ch.op)
                  OP_ALLOC: begin
                     if (req_bad) begin
                        res_status_in = ST_BADREQ;
                        state_in      = S_DONE;
                     end else if (!fit_found || (first_ff[fit_ord] >= NIL)) begin
                        res_status_in = ST_NOBLOCK;
                        state_in      = S_DONE;
                     end else begin
                        // unlink the oldest block, then split it down
                        idx_in     = first_ff[fit_ord][IDX_W-1:0];
                        ord_in     = fit_ord;
                        ro_in      = req_ro;
                        lop_ord_in = fit_ord;
                        lop_idx_in = first_ff[fit_ord][IDX_W-1:0];
                        ret_in     = S_SPLIT;
                        state_in   = S_PULL_A;
                     end
                  end
                  OP_FREE: begin
                     if ({1'b0, req_ch.free_index} >= limit) begin
                        res_status_in = ST_BADFREE;
                        state_in      = S_DONE;
                     end else begin
                        idx_in   = req_ch.free_index;
                        state_in = S_FREE_W;
                     end
                  end
                  OP_REBUILD: begin
                     for (int k = 0; k < ORDER_LEVELS; k++) begin
                        first_in[k] = NIL;
                        last_in[k]  = NIL;
                        cnt_in[k]   = '0;
                     end
                     free_in  = '0;
                     i_in     = region_first_ff;
                     bend_in  = (region_end_ff < limit) ? region_end_ff : limit;
                     build_in = 1'b1;
                     sweep_in = '0;
                     state_in = S_SWEEP;
                  end
                  default: begin
                     res_status_in = ST_BADREQ;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end

         S_BUILD: begin
            if (i_ff < bend_ff) begin
               meta_we  = 1'b1;
               meta_wa  = i_ff[IDX_W-1:0];
               meta_wd  = '{order: build_ord, marks: MK_FREE};
               push_go  = 1'b1;
               push_ord = build_ord;
               push_idx = i_ff[IDX_W-1:0];
               ret_in   = S_BUILD;
               i_in     = i_ff + (PTR_W'(1) << build_ord);
            end else begin
               build_in      = 1'b0;
               res_status_in = ST_OK;
               res_idx_in    = '0;
               res_ord_in    = '0;
               state_in      = S_DONE;
            end
         end

         S_PUSH_B: begin
            // link the old tail to the new block and advance the tail
            if ((cnt_ff[lop_ord_ff] != '0) && (last_ff[lop_ord_ff] < NIL)) begin
               next_we = 1'b1;
               next_wa = last_ff[lop_ord_ff][IDX_W-1:0];
               next_wd = {1'b0, lop_idx_ff};
            end
            if (cnt_ff[lop_ord_ff] == '0) first_in[lop_ord_ff] = {1'b0, lop_idx_ff};
            last_in[lop_ord_ff] = {1'b0, lop_idx_ff};
            cnt_in[lop_ord_ff]  = cnt_ff[lop_ord_ff] + PTR_W'(1);
            free_in             = free_ff + (FREE_W'(1) << lop_ord_ff);
            state_in            = ret_ff;
         end

         S_PULL_A: begin
            // wait for the links of the block being unlinked
            state_in = S_PULL_B;
         end

         S_PULL_B: begin
            if (prev_rd_ff < NIL) begin
               next_we = 1'b1;
               next_wa = prev_rd_ff[IDX_W-1:0];
               next_wd = next_rd_ff;
            end else begin
               first_in[lop_ord_ff] = next_rd_ff;
            end
            if (next_rd_ff < NIL) begin
               prev_we = 1'b1;
               prev_wa = next_rd_ff[IDX_W-1:0];
               prev_wd = prev_rd_ff;
            end else begin
               last_in[lop_ord_ff] = prev_rd_ff;
            end
            if (cnt_ff[lop_ord_ff] != '0) begin
               cnt_in[lop_ord_ff] = cnt_ff[lop_ord_ff] - PTR_W'(1);
               free_in            = free_ff - (FREE_W'(1) << lop_ord_ff);
            end
            state_in = ret_ff;
         end

         S_SPLIT: begin
            if (ord_ff > ro_ff) begin
               // queue the upper half one order down
               ord_in   = ord_ff - ORD_W'(1);
               meta_we  = 1'b1;
               meta_wa  = idx_ff + (IDX_W'(1) << (ord_ff - ORD_W'(1)));
               meta_wd  = '{order: ord_ff - ORD_W'(1), marks: MK_FREE};
               push_go  = 1'b1;
               push_ord = ord_ff - ORD_W'(1);
               push_idx = idx_ff + (IDX_W'(1) << (ord_ff - ORD_W'(1)));
               ret_in   = S_SPLIT;
            end else begin
               meta_we       = 1'b1;
               meta_wa       = idx_ff;
               meta_wd       = '{order: ro_ff, marks: MK_ALLOC};
               res_status_in = ST_OK;
               res_idx_in    = idx_ff;
               res_ord_in    = ro_ff;
               state_in      = S_DONE;
            end
         end

         S_FREE_W: state_in = S_FREE_RD;

         S_FREE_RD: begin
            if (meta_rd_ff.marks != MK_ALLOC) begin
               res_status_in = ST_BADFREE;
               state_in      = S_DONE;
            end else begin
               ord_in   = meta_rd_ff.order;
               meta_we  = 1'b1;
               meta_wa  = idx_ff;
               meta_wd  = '{order: meta_rd_ff.order, marks: MK_FREE};
               push_go  = 1'b1;
               push_ord = meta_rd_ff.order;
               push_idx = idx_ff;
               ret_in   = S_MERGE_CHK;
            end
         end

         S_MERGE_CHK: begin
            if ((ord_ff < ORD_W'(ORDER_LEVELS - 1)) && ({1'b0, bud_cand} < limit)) begin
               bud_in   = bud_cand;
               state_in = S_MERGE_W;
            end else begin
               res_status_in = ST_OK;
               res_idx_in    = idx_ff;
               res_ord_in    = ord_ff;
               state_in      = S_DONE;
            end
         end

         S_MERGE_W: state_in = S_MERGE_RD;

         S_MERGE_RD: begin
            if ((meta_rd_ff.marks == MK_FREE) && (meta_rd_ff.order == ord_ff)) begin
               lop_ord_in = ord_ff;
               lop_idx_in = idx_ff;
               ret_in     = S_MERGE_P2;
               state_in   = S_PULL_A;
            end else begin
               res_status_in = ST_OK;
               res_idx_in    = idx_ff;
               res_ord_in    = ord_ff;
               state_in      = S_DONE;
            end
         end

         S_MERGE_P2: begin
            lop_ord_in = ord_ff;
            lop_idx_in = bud_ff;
            ret_in     = S_HI;
            state_in   = S_PULL_A;
         end

         S_HI: begin
            meta_we  = 1'b1;
            meta_wa  = hi_page;
            meta_wd  = '{order: '0, marks: MK_NONE};
            state_in = S_LO;
         end

         S_LO: begin
            meta_we  = 1'b1;
            meta_wa  = lo_page;
            meta_wd  = '{order: ord_up, marks: MK_FREE};
            push_go  = 1'b1;
            push_ord = ord_up;
            push_idx = lo_page;
            idx_in   = lo_page;
            ord_in   = ord_up;
            ret_in   = S_MERGE_CHK;
         end

         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_ord_in    = res_ord_ff;
               rsp_free_in   = free_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // first half of a push: terminate the new block's links
      if (push_go) begin
         next_we    = 1'b1;
         next_wa    = push_idx;
         next_wd    = NIL;
         prev_we    = 1'b1;
         prev_wa    = push_idx;
         prev_wd    = (cnt_ff[push_ord] != '0) ? last_ff[push_ord] : NIL;
         lop_ord_in = push_ord;
         lop_idx_in = push_idx;
         state_in   = S_PUSH_B;
      end
   end

   // memories: one write and one registered read each cycle
   always_ff @(posedge clock) begin
      meta_rd_ff <= meta_mem[meta_ra];
      if (meta_we) meta_mem[meta_wa] <= meta_wd;
   end

   always_ff @(posedge clock) begin
      next_rd_ff <= next_mem[lop_idx_ff];
      prev_rd_ff <= prev_mem[lop_idx_ff];
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
   end

   // payload registers
   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      idx_ff        <= idx_in;
      bud_ff        <= bud_in;
      ord_ff        <= ord_in;
      ro_ff         <= ro_in;
      lop_ord_ff    <= lop_ord_in;
      lop_idx_ff    <= lop_idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_ord_ff    <= res_ord_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_ord_ff    <= rsp_ord_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // control state; reset starts a sweep with an empty region
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         i_ff         <= '0;
         bend_ff      <= '0;
         build_ff     <= 1'b0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < ORDER_LEVELS; k++) begin
            first_ff[k] <= NIL;
            last_ff[k]  <= NIL;
            cnt_ff[k]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         i_ff         <= i_in;
         bend_ff      <= bend_in;
         build_ff     <= build_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_pages_ff  <= CFG_W'(NUM_PAGES);
         region_first_ff <= '0;
         region_end_ff   <= CFG_W'(NUM_PAGES);
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_TOTAL: total_pages_ff  <= csr_ch.data;
            CSR_FIRST: region_first_ff <= csr_ch.data;
            CSR_END:   region_end_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

@@ src/bpa_checker.sv @@
`default_nettype none
module bpa_checker import bpa_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [1:0]        rsp_status,
   input wire logic [IDX_W-1:0]  rsp_page_index,
   input wire logic [ORD_W-1:0]  rsp_block_order,
   input wire logic [FREE_W-1:0] rsp_free_pages
);

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_free_pages))
      else $error("stalled result dropped or changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_page_index == '0) && (rsp_block_order == '0))
      else $error("error result carries a block");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_pages <= FREE_W'(NUM_PAGES)) &&
                    (rsp_block_order < ORD_W'(ORDER_LEVELS)))
      else $error("free count or order out of range");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_page_index  (rsp_ch.page_index),
   .rsp_block_order (rsp_ch.block_order),
   .rsp_free_pages  (rsp_ch.free_pages)
);
`default_nettype wire

@@ tb/buddy_page_allocator_tb.sv @@
`timescale 1ns / 100ps
module buddy_page_allocator_tb;
   import bpa_pkg::*;

   typedef struct packed {
      logic [1:0]        status;
      logic [IDX_W-1:0]  page_index;
      logic [ORD_W-1:0]  block_order;
      logic [FREE_W-1:0] free_pages;
   } alloc_rsp_type;

   typedef struct {
      logic [1:0]       op;
      logic [REQ_W-1:0] pages;
      logic [IDX_W-1:0] index;
      bit               typed;
      alloc_rsp_type    rsp;
   } plan_row_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 150;

   logic clock = 1'b0;
   logic reset;

   bpa_req_if req_ch ();
   bpa_rsp_if rsp_ch ();
   bpa_csr_if csr_ch ();

   buddy_page_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow allocator state: per-page order and marks, intrusive FIFO links,
   // per-order list heads, tails and counts, plus the three registers.
   int unsigned pg_order [NUM_PAGES];
   int unsigned pg_marks [NUM_PAGES];
   int unsigned lnk_next [NUM_PAGES];
   int unsigned lnk_prev [NUM_PAGES];
   int unsigned lst_head [ORDER_LEVELS];
   int unsigned lst_tail [ORDER_LEVELS];
   int unsigned lst_cnt  [ORDER_LEVELS];
   int unsigned reg_total, reg_first, reg_end;

   alloc_rsp_type expected_rsp[$];
   int unsigned   held_blocks[$];   // heads currently allocated, candidates for free
   bit            failed = 1'b0;
   int            idle_cycles = 0;
   int            rsp_wait = 0;

   function automatic int unsigned page_limit();
      return (reg_total < NUM_PAGES) ? reg_total : NUM_PAGES;
   endfunction

   function automatic void clear_free_lists();
      for (int o = 0; o < ORDER_LEVELS; o++) begin
         lst_head[o] = NUM_PAGES;
         lst_tail[o] = NUM_PAGES;
         lst_cnt[o]  = 0;
      end
   endfunction

   function automatic void queue_block(int unsigned o, int unsigned idx);
      lnk_next[idx] = NUM_PAGES;
      if (lst_cnt[o] == 0) begin
         lnk_prev[idx] = NUM_PAGES;
         lst_head[o] = idx;
      end else begin
         lnk_prev[idx] = lst_tail[o];
         if (lst_tail[o] < NUM_PAGES) lnk_next[lst_tail[o]] = idx;
      end
      lst_tail[o] = idx;
      lst_cnt[o]++;
   endfunction

   function automatic void unlink_block(int unsigned o, int unsigned idx);
      int unsigned p, n;
      p = lnk_prev[idx];
      n = lnk_next[idx];
      if (p < NUM_PAGES) lnk_next[p] = n; else lst_head[o] = n;
      if (n < NUM_PAGES) lnk_prev[n] = p; else lst_tail[o] = p;
      if (lst_cnt[o] > 0) lst_cnt[o]--;
   endfunction

   function automatic logic [FREE_W-1:0] free_page_total();
      int unsigned s;
      s = 0;
      for (int o = 0; o < ORDER_LEVELS; o++) s += lst_cnt[o] << o;
      return FREE_W'(s);
   endfunction

   function automatic void rebuild_free_lists();
      int unsigned stop, i, o;
      stop = (reg_end < page_limit()) ? reg_end : page_limit();
      for (int p = 0; p < NUM_PAGES; p++) begin
         pg_marks[p] = MK_RSVD;
         pg_order[p] = 0;
      end
      clear_free_lists();
      i = reg_first;
      while (i < stop) begin
         o = 0;
         while (o + 1 < ORDER_LEVELS && (i & ((2 << o) - 1)) == 0 && i + (2 << o) <= stop)
            o++;
         for (int j = 0; j < (1 << o); j++) pg_marks[i + j] = MK_NONE;
         pg_marks[i] = MK_FREE;
         pg_order[i] = o;
         queue_block(o, i);
         i += 1 << o;
      end
   endfunction

   function automatic alloc_rsp_type predict_allocator(logic [1:0] op, logic [REQ_W-1:0] pages,
                                                       logic [IDX_W-1:0] index);
      alloc_rsp_type r;
      int unsigned   ro, fo, idx, o, bud, lo, hi, up;
      r = '0;
      case (op)
         OP_ALLOC: begin
            if (pages == 0 || pages > (1 << (ORDER_LEVELS - 1))) begin
               r.status = ST_BADREQ;
            end else begin
               ro = 0;
               while ((1 << ro) < pages) ro++;
               fo = ro;
               while (fo < ORDER_LEVELS && lst_cnt[fo] == 0) fo++;
               if (fo >= ORDER_LEVELS || lst_head[fo] >= NUM_PAGES) begin
                  r.status = ST_NOBLOCK;
               end else begin
                  idx = lst_head[fo];
                  unlink_block(fo, idx);
                  // split down, queueing each upper half
                  while (fo > ro) begin
                     fo--;
                     up = idx + (1 << fo);
                     if (up < NUM_PAGES) begin
                        pg_order[up] = fo;
                        pg_marks[up] = MK_FREE;
                        queue_block(fo, up);
                     end
                  end
                  pg_order[idx] = ro;
                  pg_marks[idx] = MK_ALLOC;
                  r.page_index  = IDX_W'(idx);
                  r.block_order = ORD_W'(ro);
               end
            end
         end
         OP_FREE: begin
            if (index >= page_limit() || pg_marks[index] != MK_ALLOC) begin
               r.status = ST_BADFREE;
            end else begin
               idx = index;
               o = pg_order[idx];
               pg_marks[idx] = MK_FREE;
               queue_block(o, idx);
               // merge while the buddy is a free head of the same order
               while (o + 1 < ORDER_LEVELS) begin
                  bud = idx ^ (1 << o);
                  if (bud >= page_limit() || pg_marks[bud] != MK_FREE || pg_order[bud] != o)
                     break;
                  unlink_block(o, idx);
                  unlink_block(o, bud);
                  lo = (idx < bud) ? idx : bud;
                  hi = (idx < bud) ? bud : idx;
                  pg_marks[hi] = MK_NONE;
                  pg_order[hi] = 0;
                  o++;
                  pg_order[lo] = o;
                  pg_marks[lo] = MK_FREE;
                  queue_block(o, lo);
                  idx = lo;
               end
               r.page_index  = IDX_W'(idx);
               r.block_order = ORD_W'(o);
            end
         end
         OP_REBUILD: rebuild_free_lists();
         default: r.status = ST_BADREQ;
      endcase
      r.free_pages = free_page_total();
      return r;
   endfunction

   // Send one request after a random gap; valid stays high across back-to-back requests.
   task automatic send_request(logic [1:0] op, logic [REQ_W-1:0] pages,
                               logic [IDX_W-1:0] index, bit typed, alloc_rsp_type typed_rsp);
      int            gap;
      alloc_rsp_type r;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.op            <= op;
      req_ch.request_pages <= pages;
      req_ch.free_index    <= index;
      do @(posedge clock); while (!req_ch.ready);
      r = predict_allocator(op, pages, index);
      if (op == OP_ALLOC && r.status == ST_OK) held_blocks.push_back(r.page_index);
      if (op == OP_REBUILD) held_blocks.delete();
      expected_rsp.push_back(typed ? typed_rsp : r);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (index)
         CSR_TOTAL: reg_total = data;
         CSR_FIRST: reg_first = data;
         CSR_END:   reg_end   = data;
         default: ;
      endcase
   endtask

   // Hold until every expected response has arrived, then let the block settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(int unsigned total, int unsigned first, int unsigned stop);
      drain();
      write_register(CSR_TOTAL, CFG_W'(total));
      write_register(CSR_FIRST, CFG_W'(first));
      write_register(CSR_END, CFG_W'(stop));
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random traffic: mostly allocate and free of held blocks, some noise.
   task automatic random_traffic(int count);
      int               pick, slot;
      logic [REQ_W-1:0] pages;
      logic [IDX_W-1:0] index;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            case ($urandom_range(0, 9))
               0:       pages = REQ_W'($urandom_range(1, 512));
               1:       pages = ($urandom_range(0, 1) == 0) ? '0 :
                                REQ_W'($urandom_range(513, 1023));
               default: pages = REQ_W'($urandom_range(1, 16));
            endcase
            send_request(OP_ALLOC, pages, IDX_W'($urandom), 1'b0, '0);
         end else if (pick < 90 && held_blocks.size() != 0) begin
            slot  = $urandom_range(0, held_blocks.size() - 1);
            index = IDX_W'(held_blocks[slot]);
            held_blocks.delete(slot);
            send_request(OP_FREE, REQ_W'($urandom), index, 1'b0, '0);
         end else if (pick < 96) begin
            send_request(OP_FREE, REQ_W'($urandom), IDX_W'($urandom), 1'b0, '0);
         end else if (pick < 98) begin
            send_request(OP_REBUILD, REQ_W'($urandom), IDX_W'($urandom), 1'b0, '0);
         end else begin
            send_request(OP_UNUSED, REQ_W'($urandom), IDX_W'($urandom), 1'b0, '0);
         end
      end
   endtask

   function automatic alloc_rsp_type rsp_of(logic [1:0] st, int unsigned idx, int unsigned ord,
                                            int unsigned fp);
      return '{st, IDX_W'(idx), ORD_W'(ord), FREE_W'(fp)};
   endfunction

   // Response check and randomized back-pressure.
   always @(posedge clock) begin
      alloc_rsp_type want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response status=%0d index=%0d order=%0d free=%0d",
                     $time, rsp_ch.status, rsp_ch.page_index, rsp_ch.block_order,
                     rsp_ch.free_pages);
            failed = 1'b1;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_ch.status);
               failed = 1'b1;
            end
            if (rsp_ch.page_index !== want.page_index) begin
               $display("%0t: page_index expected %0d actual %0d", $time, want.page_index,
                        rsp_ch.page_index);
               failed = 1'b1;
            end
            if (rsp_ch.block_order !== want.block_order) begin
               $display("%0t: block_order expected %0d actual %0d", $time, want.block_order,
                        rsp_ch.block_order);
               failed = 1'b1;
            end
            if (rsp_ch.free_pages !== want.free_pages) begin
               $display("%0t: free_pages expected %0d actual %0d", $time, want.free_pages,
                        rsp_ch.free_pages);
               failed = 1'b1;
            end
         end
         rsp_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      end else if (rsp_wait > 0) begin
         rsp_wait--;
      end
      rsp_ch.ready <= (rsp_wait == 0);
   end

   // Watchdog: count cycles with no handshake on any channel.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("buddy_page_allocator test failed");
            $finish;
         end
      end
   end

   initial begin
      plan_row_type plan[$];
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.op            = OP_ALLOC;
      req_ch.request_pages = '0;
      req_ch.free_index    = '0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = CSR_TOTAL;
      csr_ch.data          = '0;

      reg_total = NUM_PAGES;
      reg_first = 0;
      reg_end   = NUM_PAGES;
      for (int p = 0; p < NUM_PAGES; p++) begin
         pg_order[p] = 0;
         pg_marks[p] = MK_RSVD;
         lnk_next[p] = 0;
         lnk_prev[p] = 0;
      end
      clear_free_lists();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty after reset, bad requests, unknown op, full rebuild,
      // largest blocks, double free, merge back to the top order, splits.
      plan = '{
         '{OP_ALLOC,   10'd1,    10'd0,    1'b1, rsp_of(ST_NOBLOCK, 0, 0, 0)},
         '{OP_FREE,    10'd0,    10'd0,    1'b1, rsp_of(ST_BADFREE, 0, 0, 0)},
         '{OP_UNUSED,  10'd1023, 10'd1023, 1'b1, rsp_of(ST_BADREQ, 0, 0, 0)},
         '{OP_ALLOC,   10'd0,    10'd0,    1'b1, rsp_of(ST_BADREQ, 0, 0, 0)},
         '{OP_ALLOC,   10'd513,  10'd0,    1'b1, rsp_of(ST_BADREQ, 0, 0, 0)},
         '{OP_ALLOC,   10'd1023, 10'd0,    1'b1, rsp_of(ST_BADREQ, 0, 0, 0)},
         '{OP_REBUILD, 10'd0,    10'd0,    1'b1, rsp_of(ST_OK, 0, 0, 1024)},
         '{OP_ALLOC,   10'd512,  10'd0,    1'b1, rsp_of(ST_OK, 0, 9, 512)},
         '{OP_ALLOC,   10'd512,  10'd0,    1'b1, rsp_of(ST_OK, 512, 9, 0)},
         '{OP_ALLOC,   10'd1,    10'd0,    1'b1, rsp_of(ST_NOBLOCK, 0, 0, 0)},
         '{OP_FREE,    10'd0,    10'd512,  1'b1, rsp_of(ST_OK, 512, 9, 512)},
         '{OP_FREE,    10'd0,    10'd512,  1'b1, rsp_of(ST_BADFREE, 0, 0, 512)},
         '{OP_FREE,    10'd0,    10'd1023, 1'b1, rsp_of(ST_BADFREE, 0, 0, 512)},
         '{OP_FREE,    10'd0,    10'd0,    1'b1, rsp_of(ST_OK, 0, 9, 1024)},
         '{OP_ALLOC,   10'd1,    10'd0,    1'b0, '0},
         '{OP_ALLOC,   10'd3,    10'd0,    1'b0, '0},
         '{OP_ALLOC,   10'd257,  10'd0,    1'b0, '0},
         '{OP_FREE,    10'd0,    10'd1,    1'b0, '0},
         '{OP_FREE,    10'd0,    10'd4,    1'b0, '0},
         '{OP_FREE,    10'd0,    10'd0,    1'b0, '0},
         '{OP_FREE,    10'd0,    10'd512,  1'b0, '0},
         '{OP_ALLOC,   10'd2,    10'd0,    1'b0, '0}
      };
      foreach (plan[k])
         send_request(plan[k].op, plan[k].pages, plan[k].index, plan[k].typed, plan[k].rsp);
      held_blocks.delete();
      random_traffic(150);

      // Register settings: empty region, odd bounds, out-of-range values, shrunk total.
      configure(0, 0, 1024);
      send_request(OP_REBUILD, '0, '0, 1'b1, rsp_of(ST_OK, 0, 0, 0));
      random_traffic(60);
      configure(1000, 3, 997);
      send_request(OP_REBUILD, '0, '0, 1'b0, '0);
      random_traffic(170);
      configure(2047, 100, 2047);
      send_request(OP_REBUILD, '0, '0, 1'b0, '0);
      random_traffic(170);
      configure(1024, 1024, 0);
      send_request(OP_REBUILD, '0, '0, 1'b1, rsp_of(ST_OK, 0, 0, 0));
      random_traffic(40);
      configure(1024, 0, 1024);
      send_request(OP_REBUILD, '0, '0, 1'b0, '0);
      random_traffic(180);
      configure(300, 0, 1024);
      random_traffic(150);
      configure(1024, 1, 1023);
      send_request(OP_REBUILD, '0, '0, 1'b0, '0);
      random_traffic(200);

      drain();
      if (!failed) begin
         $display("buddy_page_allocator test passed");
      end else begin
         $display("buddy_page_allocator test failed");
      end
      $finish;
   end

endmodule
